FILE: rtl/core/pcsl_pkg.sv
// ----------------------------------------------------------------------------
// pcsl_pkg
// Shared types, constants and helpers for the clamped, slew-limited PID block.
// ----------------------------------------------------------------------------
package pcsl_pkg;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_KP    = 3'd0;
   localparam logic [2:0] CSR_KI    = 3'd1;
   localparam logic [2:0] CSR_KD    = 3'd2;
   localparam logic [2:0] CSR_LIMIT = 3'd3;
   localparam logic [2:0] CSR_SLEW  = 3'd4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // reset values of the limit registers
   localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;
   localparam logic [46:0] SLEW_RESET  = 47'h7FFF_FFFF_FFFF;

   // magnitude cap for every scaled product: 2^40
   localparam logic [40:0] MAG_CAP = 41'h100_0000_0000;

   // products formed on the shared limb multiplier
   typedef enum logic [2:0] {
      OP_D,    // |kd| * |e - e_prev|, then divided by dt
      OP_P,    // |kp| * |e|
      OP_S,    // slew * dt
      OP_I1,   // |ki| * |e + e_prev|
      OP_I2    // previous product * dt
   } op_type;

   typedef struct packed {
      logic   load_in;
      logic   prep;
      logic   mul;
      logic   acc;
      logic   fin;
      logic   comb_i;
      logic   comb_s;
      logic   comb_r;
      logic   out_load;
      op_type op;
      logic [1:0] limb;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic div_done;
   } status_type;

   // number of 32-bit limbs of the wide operand per product
   function automatic logic [1:0] op_limbs(input op_type op);
      logic [1:0] n;
      case (op)
         OP_P:    n = 2'd1;
         OP_I2:   n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   // saturate a magnitude at 2^40
   function automatic logic [40:0] sat_mag(input logic [68:0] v);
      logic [40:0] r;
      if (v > 69'(MAG_CAP)) r = MAG_CAP;
      else                  r = v[40:0];
      return r;
   endfunction

endpackage

FILE: rtl/core/pcsl_if.sv
// ----------------------------------------------------------------------------
// pcsl channel interfaces
// Valid/ready channels for input samples, drive results and csr writes.
// ----------------------------------------------------------------------------
interface pcsl_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] error_in;
   logic        [31:0] time_us;

   modport source (output valid, output error_in, output time_us, input ready);
   modport sink   (input valid, input error_in, input time_us, output ready);
endinterface

interface pcsl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_out;

   modport source (output valid, output drive_out, input ready);
   modport sink   (input valid, input drive_out, output ready);
endinterface

interface pcsl_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [pcsl_pkg::CSR_IDX_W-1:0]  index;
   logic [pcsl_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pcsl_div.sv
// ----------------------------------------------------------------------------
// pcsl_div
// Restoring divider, one quotient bit per cycle, rounded and saturated.
// ----------------------------------------------------------------------------
module pcsl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [72:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [40:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [6:0]  cnt_ff;
   logic [47:0] rem_ff;
   logic [72:0] q_ff;
   logic [47:0] d_ff;

   logic [48:0] trial;
   logic        fits;
   logic        rnd;
   logic [73:0] q_rnd;

   // trial subtraction
   assign trial = {rem_ff, q_ff[72]};
   assign fits  = trial >= {1'b0, d_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd72;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
   end

   // remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= dividend;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? 48'(trial - {1'b0, d_ff}) : trial[47:0];
         q_ff   <= {q_ff[71:0], fits};
      end
   end

   // round half away from zero, then cap
   assign rnd   = {rem_ff, 1'b0} >= {1'b0, d_ff};
   assign q_rnd = {1'b0, q_ff} + {73'd0, rnd};
   assign quot  = (q_rnd > 74'(pcsl_pkg::MAG_CAP)) ? pcsl_pkg::MAG_CAP : q_rnd[40:0];
   assign done  = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("divider done without run");

endmodule

FILE: rtl/core/pcsl_dpath.sv
// ----------------------------------------------------------------------------
// pcsl_dpath
// Datapath: csr registers, loop state, limb multiplier, divider and clamps.
// ----------------------------------------------------------------------------
module pcsl_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  pcsl_pkg::cmd_type               cmd,
   output pcsl_pkg::status_type            status,
   input  logic signed [31:0]              error_in,
   input  logic        [31:0]              time_us,
   input  logic                            csr_we,
   input  logic [pcsl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcsl_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed [31:0]              drive_out
);

   // configuration
   logic signed [31:0] kp_ff;
   logic signed [47:0] ki_ff;
   logic signed [39:0] kd_ff;
   logic        [30:0] lim_ff;
   logic        [46:0] slew_ff;

   // loop state
   logic               started_ff;
   logic        [31:0] last_time_ff;
   logic signed [31:0] integral_ff;
   logic signed [31:0] last_error_ff;
   logic signed [31:0] last_output_ff;

   // current item
   logic signed [31:0] e_ff;
   logic        [31:0] t_ff;
   logic               first_ff;
   logic        [31:0] dt_ff;
   logic        [32:0] mesum_ff;
   logic        [32:0] mediff_ff;
   logic               neg_i_ff;
   logic               neg_d_ff;

   // products and terms
   logic        [64:0]  pp_ff;
   logic        [113:0] acc_ff;
   logic        [80:0]  ti_ff;
   logic signed [41:0]  p_ff;
   logic signed [41:0]  it_ff;
   logic        [40:0]  s_ff;
   logic signed [31:0]  i_ff;
   logic signed [31:0]  sum_ff;
   logic signed [31:0]  res_ff;
   logic signed [31:0]  drive_ff;

   logic        [31:0] dt_raw;
   logic signed [32:0] esum;
   logic signed [32:0] ediff;
   logic        [31:0] me;
   logic        [31:0] mkp;
   logic        [47:0] mki;
   logic        [39:0] mkd;
   logic        [95:0] op_a;
   logic        [32:0] op_b;
   logic        [31:0] limb_a;
   logic        [113:0] pp_sh;
   logic        [64:0]  p_rnd;
   logic        [79:0]  s_rnd;
   logic        [113:0] i_rnd;
   logic        [40:0]  d_mag;
   logic               div_done;
   logic signed [41:0] d_val;
   logic signed [42:0] i_sum;
   logic signed [43:0] pid_sum;
   logic signed [42:0] diff;
   logic signed [42:0] step;

   function automatic logic signed [31:0] clamp(input logic signed [43:0] x,
                                                input logic [30:0] lim);
      logic signed [43:0] l;
      logic signed [31:0] r;
      l = signed'({13'd0, lim});
      if (x > l)       r = 32'(l);
      else if (x < -l) r = 32'(-l);
      else             r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [41:0] apply_sign(input logic [40:0] m, input logic neg);
      logic signed [41:0] v;
      v = signed'({1'b0, m});
      return neg ? -v : v;
   endfunction

   // magnitudes
   assign me  = e_ff[31]  ? 32'(-e_ff)  : 32'(e_ff);
   assign mkp = kp_ff[31] ? 32'(-kp_ff) : 32'(kp_ff);
   assign mki = ki_ff[47] ? 48'(-ki_ff) : 48'(ki_ff);
   assign mkd = kd_ff[39] ? 40'(-kd_ff) : 40'(kd_ff);

   // item preparation terms
   assign dt_raw = t_ff - last_time_ff;
   assign esum   = 33'(e_ff) + 33'(last_error_ff);
   assign ediff  = 33'(e_ff) - 33'(last_error_ff);

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         lim_ff  <= pcsl_pkg::LIMIT_RESET;
         slew_ff <= pcsl_pkg::SLEW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pcsl_pkg::CSR_KP:    kp_ff   <= csr_data[31:0];
            pcsl_pkg::CSR_KI:    ki_ff   <= csr_data[47:0];
            pcsl_pkg::CSR_KD:    kd_ff   <= csr_data[39:0];
            pcsl_pkg::CSR_LIMIT: lim_ff  <= csr_data[30:0];
            pcsl_pkg::CSR_SLEW:  slew_ff <= csr_data[46:0];
            default: ;
         endcase
      end
   end

   // loop state, updated when the result is handed out
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         last_time_ff   <= '0;
         integral_ff    <= '0;
         last_error_ff  <= '0;
         last_output_ff <= '0;
      end else if (cmd.out_load) begin
         started_ff   <= 1'b1;
         last_time_ff <= t_ff;
         if (!first_ff) begin
            integral_ff    <= i_ff;
            last_error_ff  <= e_ff;
            last_output_ff <= res_ff;
         end
      end
   end

   // input capture and per-item preparation
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         e_ff     <= error_in;
         t_ff     <= time_us;
         first_ff <= !started_ff;
      end
      if (cmd.prep) begin
         dt_ff     <= (dt_raw == 32'd0) ? 32'd1 : dt_raw;
         mesum_ff  <= esum[32]  ? 33'(-esum)  : 33'(esum);
         mediff_ff <= ediff[32] ? 33'(-ediff) : 33'(ediff);
         neg_i_ff  <= ki_ff[47] ^ esum[32];
         neg_d_ff  <= kd_ff[39] ^ ediff[32];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.op)
         pcsl_pkg::OP_D:  begin op_a = 96'(mkd);     op_b = mediff_ff;       end
         pcsl_pkg::OP_P:  begin op_a = 96'(me);      op_b = {1'b0, mkp};     end
         pcsl_pkg::OP_S:  begin op_a = 96'(slew_ff); op_b = {1'b0, dt_ff};   end
         pcsl_pkg::OP_I1: begin op_a = 96'(mki);     op_b = mesum_ff;        end
         default:         begin op_a = 96'(ti_ff);   op_b = {1'b0, dt_ff};   end
      endcase
      case (cmd.limb)
         2'd0:    limb_a = op_a[31:0];
         2'd1:    limb_a = op_a[63:32];
         default: limb_a = op_a[95:64];
      endcase
      case (cmd.limb)
         2'd0:    pp_sh = 114'(pp_ff);
         2'd1:    pp_sh = 114'({pp_ff, 32'd0});
         default: pp_sh = 114'({pp_ff, 64'd0});
      endcase
   end

   // rounding of finished products
   assign p_rnd = {1'b0, acc_ff[63:0]} + 65'd32768;
   assign s_rnd = {1'b0, acc_ff[78:0]} + 80'd134217728;
   assign i_rnd = {1'b0, acc_ff[112:0]} + (114'd1 << 44);

   // multiply, accumulate, and store finished terms
   always_ff @(posedge clock) begin
      if (cmd.mul) pp_ff <= {33'd0, limb_a} * {32'd0, op_b};
      if (cmd.prep || cmd.fin) acc_ff <= '0;
      else if (cmd.acc)        acc_ff <= acc_ff + pp_sh;
      if (cmd.fin) begin
         case (cmd.op)
            pcsl_pkg::OP_P:
               p_ff <= apply_sign(pcsl_pkg::sat_mag(69'(p_rnd[64:16])), kp_ff[31] ^ e_ff[31]);
            pcsl_pkg::OP_S:  s_ff  <= pcsl_pkg::sat_mag(69'(s_rnd[79:28]));
            pcsl_pkg::OP_I1: ti_ff <= acc_ff[80:0];
            pcsl_pkg::OP_I2: it_ff <= apply_sign(pcsl_pkg::sat_mag(i_rnd[113:45]), neg_i_ff);
            default: ;
         endcase
      end
   end

   // derivative divide by dt in units of Q32.16
   pcsl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.fin && (cmd.op == pcsl_pkg::OP_D)),
      .dividend (acc_ff[72:0]),
      .divisor  ({dt_ff, 16'd0}),
      .done     (div_done),
      .quot     (d_mag)
   );

   assign d_val   = apply_sign(d_mag, neg_d_ff);
   assign i_sum   = 43'(integral_ff) + 43'(it_ff);
   assign pid_sum = 44'(p_ff) + 44'(i_ff) + 44'(d_val);
   assign diff    = 43'(sum_ff) - 43'(last_output_ff);
   assign step    = signed'({2'b0, s_ff});

   // clamps and slew limit
   always_ff @(posedge clock) begin
      if (cmd.comb_i) i_ff   <= clamp(44'(i_sum), lim_ff);
      if (cmd.comb_s) sum_ff <= clamp(pid_sum, lim_ff);
      if (cmd.comb_r) begin
         if (diff > step)       res_ff <= 32'(43'(last_output_ff) + step);
         else if (diff < -step) res_ff <= 32'(43'(last_output_ff) - step);
         else                   res_ff <= sum_ff;
      end
      if (cmd.out_load) drive_ff <= first_ff ? 32'sd0 : res_ff;
   end

   assign drive_out       = drive_ff;
   assign status.started  = started_ff;
   assign status.div_done = div_done;

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && first_ff) |=> (drive_ff == 32'sd0))
      else $error("first result not zero");

   a_slew_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.comb_r |=> ((43'(res_ff) - 43'(last_output_ff) <= step)
                   && (43'(res_ff) - 43'(last_output_ff) >= -step)))
      else $error("slew limit exceeded");

endmodule

FILE: rtl/core/pcsl_ctrl.sv
// ----------------------------------------------------------------------------
// pcsl_ctrl
// Sequencer: input accept, product schedule, divider wait, result hand-off.
// ----------------------------------------------------------------------------
module pcsl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pcsl_pkg::status_type status,
   output pcsl_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_ACC, ST_FIN, ST_DIVW,
      ST_COMB_I, ST_COMB_S, ST_COMB_R, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   pcsl_pkg::op_type op_ff, op_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_load;
   logic             last_limb;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign last_limb = (cnt_ff == 2'(pcsl_pkg::op_limbs(op_ff) - 2'd1));

   // next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) rsp_valid_in = 1'b1;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = status.started ? ST_PREP : ST_DONE;
         ST_PREP: begin
            op_in    = pcsl_pkg::OP_D;
            cnt_in   = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL:    state_in = ST_ACC;
         ST_ACC: begin
            if (last_limb) state_in = ST_FIN;
            else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            cnt_in   = 2'd0;
            state_in = ST_MUL;
            case (op_ff)
               pcsl_pkg::OP_D:  op_in = pcsl_pkg::OP_P;
               pcsl_pkg::OP_P:  op_in = pcsl_pkg::OP_S;
               pcsl_pkg::OP_S:  op_in = pcsl_pkg::OP_I1;
               pcsl_pkg::OP_I1: op_in = pcsl_pkg::OP_I2;
               default:         state_in = ST_DIVW;
            endcase
         end
         ST_DIVW:   if (status.div_done) state_in = ST_COMB_I;
         ST_COMB_I: state_in = ST_COMB_S;
         ST_COMB_S: state_in = ST_COMB_R;
         ST_COMB_R: state_in = ST_DONE;
         ST_DONE:   if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= pcsl_pkg::OP_D;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.load_in  = accept;
      cmd.prep     = (state_ff == ST_PREP);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.fin      = (state_ff == ST_FIN);
      cmd.comb_i   = (state_ff == ST_COMB_I);
      cmd.comb_s   = (state_ff == ST_COMB_S);
      cmd.comb_r   = (state_ff == ST_COMB_R);
      cmd.out_load = out_load;
      cmd.op       = op_ff;
      cmd.limb     = cnt_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside hand-off");

   a_limb_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < pcsl_pkg::op_limbs(op_ff)))
      else $error("limb index out of range");

   a_div_before_comb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMB_I) |-> $past(status.div_done))
      else $error("terms combined before divide finished");

endmodule

FILE: rtl/core/pid_clamped_slew_limited.sv
// Input-to-result time is set by the 73-step restoring divider for the
//   derivative term; the other products run on the shared 32x33 limb
//   multiplier while it divides. The first item after reset skips the products.
// One item at a time: a new input is taken only after the last result is loaded.
// Reset: gains clear, limits go to full scale, loop state clears.
// ----------------------------------------------------------------------------
// pid_clamped_slew_limited
// PID controller with trapezoidal integral, output clamp and slew limit.
// ----------------------------------------------------------------------------
module pid_clamped_slew_limited (
   input  logic       clock,
   input  logic       reset,
   pcsl_req_if.sink   req_ch,
   pcsl_rsp_if.source rsp_ch,
   pcsl_csr_if.sink   csr_ch
);

   pcsl_pkg::cmd_type    cmd;
   pcsl_pkg::status_type status;

   // csr writes are always taken
   assign csr_ch.ready = 1'b1;

   pcsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcsl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .error_in  (req_ch.error_in),
      .time_us   (req_ch.time_us),
      .csr_we    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .drive_out (rsp_ch.drive_out)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clamped, slew-limited PID block. A queue-fed
// driver sends error samples and timestamps, an in-bench drive predictor
// computes each expected output, and a monitor compares every rsp transfer.
// Gains and limits are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [31:0] err;
      logic [31:0] stamp;
   } sample_type;

   logic clock;
   logic reset;

   pcsl_req_if req_ch ();
   pcsl_rsp_if rsp_ch ();
   pcsl_csr_if csr_ch ();

   pid_clamped_slew_limited dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sample_type  sample_q[$];
   logic [31:0] drive_q[$];
   int          mismatches = 0;
   bit          quiet      = 0;
   bit          hold_go    = 0;
   bit          hold_off   = 0;
   logic [31:0] next_stamp = 0;

   // predictor copy of registers and loop state
   longint g_kp, g_ki, g_kd, g_limit, g_slew;
   bit          run_started;
   logic [31:0] prev_stamp;
   longint      acc_i, prev_err, prev_drive;

   initial clock = 0;
   always #10 clock = ~clock;

   initial begin
      reset         = 1;
      req_ch.valid  = 0;
      req_ch.error_in = '0;
      req_ch.time_us  = '0;
      rsp_ch.ready  = 0;
      csr_ch.valid  = 0;
      csr_ch.index  = '0;
      csr_ch.data   = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] magnitude(input longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint scale_round(input logic [127:0] num, input logic [127:0] den,
                                          input bit neg);
      logic [127:0] q;
      logic [127:0] r;
      q = num / den;
      r = num % den;
      if ((r << 1) >= den) q = q + 1;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return neg ? -longint'(q[40:0]) : longint'(q[40:0]);
   endfunction

   function automatic longint clamp_lim(input longint x, input longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic logic [31:0] predict_drive(input logic [31:0] err_bits,
                                                 input logic [31:0] stamp);
      longint      e, esum, ediff, p, i, d, sum, step, diff, res;
      logic [31:0] dt;
      e = longint'($signed(err_bits));
      if (!run_started) begin
         run_started = 1;
         prev_stamp  = stamp;
         return 32'd0;
      end
      dt = stamp - prev_stamp;
      if (dt == 0) dt = 1;
      p = scale_round(128'(magnitude(g_kp)) * 128'(magnitude(e)), 128'd1 << 16,
                      (g_kp < 0) != (e < 0));
      esum = e + prev_err;
      i = acc_i + scale_round(128'(magnitude(g_ki)) * 128'(magnitude(esum)) * 128'(dt),
                              128'd1 << 45, (g_ki < 0) != (esum < 0));
      i = clamp_lim(i, g_limit);
      ediff = e - prev_err;
      d = scale_round(128'(magnitude(g_kd)) * 128'(magnitude(ediff)), 128'(dt) << 16,
                      (g_kd < 0) != (ediff < 0));
      sum  = clamp_lim(p + i + d, g_limit);
      step = scale_round(128'(g_slew) * 128'(dt), 128'd1 << 28, 1'b0);
      diff = sum - prev_drive;
      if (diff > step)       res = prev_drive + step;
      else if (diff < -step) res = prev_drive - step;
      else                   res = sum;
      acc_i      = i;
      prev_drive = res;
      prev_err   = e;
      prev_stamp = stamp;
      return res[31:0];
   endfunction

   // ---------------------------------------------------------------- driver
   int req_gap = 0;
   always @(posedge clock) begin
      bit vld_next;
      if (reset) begin
         req_ch.valid <= 0;
         run_started = 0;
         prev_stamp  = 0;
         acc_i = 0; prev_err = 0; prev_drive = 0;
      end else begin
         vld_next = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            drive_q.push_back(predict_drive(req_ch.error_in, req_ch.time_us));
            void'(sample_q.pop_front());
            vld_next = 0;
         end
         if (!vld_next) begin
            if (req_gap > 0) req_gap--;
            else if (!quiet && $urandom_range(0, 11) == 0) req_gap = $urandom_range(1, 13);
            else if (sample_q.size() > 0) begin
               vld_next = 1;
               req_ch.error_in <= sample_q[0].err;
               req_ch.time_us  <= sample_q[0].stamp;
            end
         end
         req_ch.valid <= vld_next;
      end
   end

   // ---------------------------------------------------------------- receiver
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (hold_off) rsp_ch.ready <= 0;
      else begin
         if (rsp_gap > 0) rsp_gap--;
         else if (!quiet && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 13);
         rsp_ch.ready <= (rsp_gap == 0);
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off = 1;
      repeat (700) @(posedge clock);
      hold_off = 0;
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected drive_out transfer: %0d", $signed(rsp_ch.drive_out));
         end else begin
            want = drive_q.pop_front();
            if (rsp_ch.drive_out !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("drive_out mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(rsp_ch.drive_out));
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic csr_write(input logic [2:0] idx, input logic [47:0] value);
      @(posedge clock);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         pcsl_pkg::CSR_KP:    g_kp    = longint'($signed(value[31:0]));
         pcsl_pkg::CSR_KI:    g_ki    = longint'($signed(value[47:0]));
         pcsl_pkg::CSR_KD:    g_kd    = longint'($signed(value[39:0]));
         pcsl_pkg::CSR_LIMIT: g_limit = longint'(value[30:0]);
         pcsl_pkg::CSR_SLEW:  g_slew  = longint'(value[46:0]);
         default: ;
      endcase
      csr_ch.valid <= 0;
   endtask

   task automatic program_loop(input logic [31:0] kp, input logic [47:0] ki,
                               input logic [39:0] kd, input logic [30:0] lim,
                               input logic [46:0] slew);
      csr_write(pcsl_pkg::CSR_KP, 48'(kp));
      csr_write(pcsl_pkg::CSR_KI, ki);
      csr_write(pcsl_pkg::CSR_KD, 48'(kd));
      csr_write(pcsl_pkg::CSR_LIMIT, 48'(lim));
      csr_write(pcsl_pkg::CSR_SLEW, 48'(slew));
   endtask

   task automatic drain();
      while (sample_q.size() != 0 || drive_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic push_sample(input logic [31:0] err, input logic [31:0] stamp);
      sample_type s;
      s.err   = err;
      s.stamp = stamp;
      next_stamp = stamp;
      sample_q.push_back(s);
   endtask

   // random sample, mostly small steps in time and moderate errors
   task automatic push_random();
      logic [31:0] err;
      logic [31:0] dt;
      case ($urandom_range(0, 9))
         0:       err = $urandom;
         1:       err = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: err = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      endcase
      case ($urandom_range(0, 19))
         0:       dt = 0;
         1:       dt = $urandom;
         2:       dt = $urandom_range(1, 1000000);
         default: dt = $urandom_range(1, 2000);
      endcase
      push_sample(err, next_stamp + dt);
   endtask

   task automatic random_phase(input int n);
      repeat (n) push_random();
      drain();
   endtask

   function automatic logic [47:0] rnd48(input int bits);
      logic [47:0] v;
      v = 48'({$urandom, $urandom});
      return 48'($signed(v) >>> (48 - bits));
   endfunction

   initial begin
      g_kp = 0; g_ki = 0; g_kd = 0;
      g_limit = longint'(pcsl_pkg::LIMIT_RESET);
      g_slew  = longint'(pcsl_pkg::SLEW_RESET);
      wait (!reset);
      @(posedge clock);

      // first sample only records time, then zero gains at reset defaults
      push_sample(32'h0001_0000, 32'd100);
      push_sample(32'h7FFF_FFFF, 32'd100);
      push_sample(32'h8000_0000, 32'd150);
      drain();

      // directed: field extremes, repeated stamp, wrap, lowered limit
      program_loop(32'h0001_8000, 48'h0000_4000_0000, 40'h00_0010_0000,
                   31'h0100_0000, 47'h0000_1000_0000);
      csr_write(3'd6, 48'hFFFF_FFFF_FFFF);
      push_sample(32'h7FFF_FFFF, 32'd151);
      push_sample(32'h7FFF_FFFF, 32'd151);
      push_sample(32'h8000_0000, 32'd152);
      push_sample(32'h0000_0000, 32'd400);
      push_sample(32'hFFFF_FFFF, 32'hFFFF_FFF0);
      push_sample(32'h0000_0001, 32'h0000_0005);
      push_sample(32'h0123_4567, 32'h8000_0005);
      push_sample(32'hFFFF_0000, 32'h8000_0006);
      drain();
      program_loop(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF,
                   31'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF);
      push_sample(32'h7FFF_FFFF, 32'h8000_0010);
      push_sample(32'h8000_0000, 32'h8000_0011);
      push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      drain();
      // limit lowered below the last drive, slow slew
      program_loop(32'h7FFF_FFFF, 48'h0, 40'h0, 31'h0000_1000, 47'h0000_0001_0000);
      push_sample(32'h7FFF_FFFF, 32'h0000_0003);
      push_sample(32'h7FFF_FFFF, 32'h0000_0004);
      push_sample(32'h7FFF_FFFF, 32'h0000_0010);
      drain();
      program_loop(32'h8000_0000, 48'h8000_0000_0000, 40'h80_0000_0000, 31'h0, 47'h0);
      push_sample(32'h8000_0000, 32'h0000_0020);
      push_sample(32'h7FFF_FFFF, 32'h0000_0021);
      drain();

      // random phases with varied settings
      program_loop(32'h0000_C000, 48'h0000_0800_0000, 40'h00_0000_8000,
                   31'h0004_0000, 47'h0000_2000_0000);
      hold_go = 1;
      random_phase(110);
      repeat (4) begin
         program_loop($urandom_range(0, 1) ? 32'(rnd48(20)) : $urandom, rnd48(34),
                      40'(rnd48(26)), 31'($urandom_range(0, 32'h0100_0000)),
                      47'(rnd48(40)) & 47'h00FF_FFFF_FFFF);
         random_phase(110);
      end
      program_loop(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF,
                   31'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF);
      random_phase(100);
      quiet = 1;
      program_loop(32'hFFFF_4000, 48'hFFFF_F000_0000, 40'hFF_FFFF_0000,
                   31'h0080_0000, 47'h0000_4000_0000);
      random_phase(110);

      if (mismatches == 0 && drive_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
